// ----- rtl/led_pattern_sequencer_macros.svh -----
// Assertion macros shared by the LED pattern sequencer RTL.
// Depends on nothing; included inside module bodies that carry checks.
`ifndef LED_PATTERN_SEQUENCER_MACROS_SVH
`define LED_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lps_pkg.sv -----
// Shared types, constants and helper functions for the LED pattern sequencer.
// Used by the channel interfaces and the top level; depends on nothing.
package lps_pkg;

   // Pattern store geometry.
   localparam int PATTERN_DEPTH = 32;
   localparam int PosW          = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int LenW          = $clog2(PATTERN_DEPTH + 1);

   // Field widths of the words on the channels.
   localparam int ModeW   = 2;
   localparam int SymbolW = 8;
   localparam int LedW    = 4;
   localparam int PosOutW = 5;
   localparam int PeriodW = 16;
   localparam int CodeW   = 8;
   localparam int CsrIdxW = 1;

   // Reset values.
   localparam logic [PeriodW-1:0] PeriodMinReset = 16'd1860;
   localparam logic [PeriodW-1:0] PeriodMaxReset = 16'd29767;
   localparam logic [PeriodW-1:0] PeriodReset    = 16'd7441;
   localparam logic [LenW-1:0]    ActiveReset    = LenW'(8);
   localparam logic [SymbolW-1:0] CharZero       = 8'h30;

   // Item modes.
   typedef enum logic [ModeW-1:0] {
      MODE_TICK   = 2'd0,
      MODE_CHAR   = 2'd1,
      MODE_FASTER = 2'd2,
      MODE_SLOWER = 2'd3
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_PERIOD_MIN = 1'b0,
      CSR_PERIOD_MAX = 1'b1
   } csr_idx_type;

   // One result word.
   typedef struct packed {
      logic [LedW-1:0]    leds;
      logic [PosOutW-1:0] position;
      logic               loading;
      logic               running;
   } rsp_type;

   // Power-up contents of one store entry.
   function automatic logic [CodeW-1:0] initial_code(input int unsigned entry);
      logic [CodeW-1:0] code;
      case (entry)
         0:       code = 8'd0;
         1:       code = 8'd8;
         2:       code = 8'd12;
         3:       code = 8'd4;
         4:       code = 8'd6;
         5:       code = 8'd2;
         6:       code = 8'd3;
         7:       code = 8'd1;
         default: code = 8'd0;
      endcase
      return code;
   endfunction

   // Only these eight codes drive the LEDs.
   function automatic logic code_known(input logic [CodeW-1:0] code);
      return code inside {8'd0, 8'd8, 8'd12, 8'd4, 8'd6, 8'd2, 8'd3, 8'd1};
   endfunction

endpackage

// ----- rtl/lps_if.sv -----
// Channel interfaces of the LED pattern sequencer: request, response, CSR.
// Depends on lps_pkg for field widths and the response word type.
interface lps_req_if;
   import lps_pkg::*;
   logic               valid;
   logic               ready;
   logic [ModeW-1:0]   mode;
   logic [SymbolW-1:0] symbol;
   modport source (output valid, output mode, output symbol, input ready);
   modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface lps_rsp_if;
   import lps_pkg::*;
   logic               valid;
   logic               ready;
   logic [LedW-1:0]    leds;
   logic [PosOutW-1:0] position;
   logic               loading;
   logic               running;
   modport source (output valid, output leds, output position, output loading,
                   output running, input ready);
   modport sink   (input valid, input leds, input position, input loading,
                   input running, output ready);
endinterface

interface lps_csr_if;
   import lps_pkg::*;
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic [PeriodW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/led_pattern_sequencer.sv -----
// Top level of the LED pattern sequencer: state, pattern store and output skid.
// Depends on lps_pkg, the channel interfaces in lps_if.sv and the macro header.
//
//  channel   | direction | word
//  ----------+-----------+---------------------------------------------
//  req_chan  | in        | mode, symbol
//  rsp_chan  | out       | leds, position, loading, running
//  csr_chan  | in        | index, data (period_min or period_max)
//
// One word is accepted per cycle while the skid is empty; its response is
// registered in the output register, or in the skid stage while rsp_chan is
// stalled. A two-entry output buffer (register plus skid) keeps req_chan ready
// while one response waits on a stalled rsp_chan. csr_chan is always ready.
// Synchronous active-high reset restores the pattern store and all state registers.
module led_pattern_sequencer (
   input  logic clock,
   input  logic reset,
   lps_req_if.sink   req_chan,
   lps_rsp_if.source rsp_chan,
   lps_csr_if.sink   csr_chan
);
   import lps_pkg::*;
   `include "led_pattern_sequencer_macros.svh"

   // State registers.
   logic [PeriodW-1:0] period_min_ff, period_max_ff;
   logic [CodeW-1:0]   store_ff [PATTERN_DEPTH];
   logic [PosW-1:0]    pos_ff, pos_in;
   logic [LenW-1:0]    active_ff, active_in;
   logic               phase_ff, phase_in;
   logic [LenW-1:0]    idx_ff, idx_in;
   logic [LenW-1:0]    len_ff, len_in;
   logic [PeriodW-1:0] period_ff, period_in;
   logic [PeriodW-1:0] count_ff, count_in;
   logic               enabled_ff, enabled_in;
   logic [LedW-1:0]    led_ff, led_in;

   // Output buffer.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   // Datapath helpers.
   logic               accept;
   logic               store_we;
   logic [PosW-1:0]    store_addr;
   logic [CodeW-1:0]   store_data;
   logic [LenW-1:0]    step_inc;
   logic [PosW-1:0]    step_next;
   logic [CodeW-1:0]   step_code;
   logic [SymbolW-1:0] sym_val;
   logic [LenW-1:0]    sym_len;
   logic [LenW-1:0]    idx_inc;
   logic [PeriodW-1:0] period_half;
   logic [PeriodW:0]   period_dbl;
   rsp_type            result;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !skid_valid_ff;
   assign csr_chan.ready = 1'b1;

   // Next step position and the code stored there.
   assign step_inc  = LenW'(pos_ff) + LenW'(1);
   assign step_next = (step_inc >= active_ff || step_inc >= LenW'(PATTERN_DEPTH))
                      ? '0 : step_inc[PosW-1:0];
   assign step_code = store_ff[step_next];

   // Received character as a number, and as a saturated length.
   assign sym_val = req_chan.symbol - CharZero;
   assign sym_len = (sym_val > SymbolW'(PATTERN_DEPTH))
                    ? LenW'(PATTERN_DEPTH) : LenW'(sym_val);
   assign idx_inc = idx_ff + LenW'(1);

   // Period candidates for the two buttons.
   assign period_half = period_ff >> 1;
   assign period_dbl  = {period_ff, 1'b0};

   // Next-state logic for one accepted word.
   always_comb begin
      pos_in     = pos_ff;
      active_in  = active_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      len_in     = len_ff;
      period_in  = period_ff;
      count_in   = count_ff;
      enabled_in = enabled_ff;
      led_in     = led_ff;
      store_we   = 1'b0;
      store_addr = idx_ff[PosW-1:0];
      store_data = sym_val;
      case (req_chan.mode)
         MODE_TICK: begin
            if (enabled_ff) begin
               if (count_ff >= period_ff) begin
                  count_in = '0;
                  pos_in   = step_next;
                  if (code_known(step_code)) begin
                     led_in = step_code[LedW-1:0];
                  end
               end else begin
                  count_in = count_ff + PeriodW'(1);
               end
            end
         end
         MODE_CHAR: begin
            enabled_in = 1'b0;
            if (!phase_ff) begin
               // A length of zero is ignored; the block keeps waiting.
               if (sym_val != '0) begin
                  len_in   = sym_len;
                  idx_in   = '0;
                  phase_in = 1'b1;
               end
            end else begin
               store_we = (idx_ff < LenW'(PATTERN_DEPTH));
               idx_in   = idx_inc;
               if (idx_inc >= len_ff) begin
                  phase_in   = 1'b0;
                  idx_in     = '0;
                  pos_in     = '0;
                  active_in  = len_ff;
                  enabled_in = 1'b1;
               end
            end
         end
         MODE_FASTER: begin
            period_in  = (period_half < period_min_ff) ? period_min_ff : period_half;
            count_in   = '0;
            enabled_in = 1'b1;
         end
         MODE_SLOWER: begin
            period_in  = (period_dbl > {1'b0, period_max_ff})
                         ? period_max_ff : period_dbl[PeriodW-1:0];
            count_in   = '0;
            enabled_in = 1'b1;
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   // Response word reflects the state after this word.
   always_comb begin
      result.leds     = led_in;
      result.position = PosOutW'(pos_in);
      result.loading  = phase_in;
      result.running  = enabled_in;
   end

   // Output register with a skid stage behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!rsp_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_in       = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.leds     = rsp_ff.leds;
   assign rsp_chan.position = rsp_ff.position;
   assign rsp_chan.loading  = rsp_ff.loading;
   assign rsp_chan.running  = rsp_ff.running;

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_min_ff <= PeriodMinReset;
         period_max_ff <= PeriodMaxReset;
         pos_ff        <= '0;
         active_ff     <= ActiveReset;
         phase_ff      <= 1'b0;
         idx_ff        <= '0;
         len_ff        <= '0;
         period_ff     <= PeriodReset;
         count_ff      <= '0;
         enabled_ff    <= 1'b1;
         led_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_PERIOD_MIN: period_min_ff <= csr_chan.data;
               CSR_PERIOD_MAX: period_max_ff <= csr_chan.data;
               default:        period_min_ff <= period_min_ff;
            endcase
         end
         if (accept) begin
            pos_ff     <= pos_in;
            active_ff  <= active_in;
            phase_ff   <= phase_in;
            idx_ff     <= idx_in;
            len_ff     <= len_in;
            period_ff  <= period_in;
            count_ff   <= count_in;
            enabled_ff <= enabled_in;
            led_ff     <= led_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Response payload registers need no reset.
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   // Pattern store: reset loads the power-up pattern.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_DEPTH; i++) begin
            store_ff[i] <= initial_code(i);
         end
      end else if (accept && store_we) begin
         store_ff[store_addr] <= store_data;
      end
   end

   // The skid stage only fills behind a held output word.
   `LPS_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid without output word")
   // The load index never reaches the announced length during a load.
   `LPS_ASSERT_NOW(a_load_index, clock, reset, phase_ff, (idx_ff < len_ff) && (len_ff != '0), "load index past length")
   // The step position stays inside the active pattern.
   `LPS_ASSERT_NOW(a_pos_in_range, clock, reset, 1'b1, (LenW'(pos_ff) < active_ff) && (active_ff <= LenW'(PATTERN_DEPTH)), "position outside pattern")
   // A word taken into the skid stage is presented next once the output drains.
   `LPS_ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && rsp_chan.ready, rsp_valid_ff && (rsp_ff == $past(skid_ff)), "skid word lost")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the LED pattern sequencer top level.
// Depends on lps_pkg and the channel interfaces in lps_if.sv; a built-in
// predictor forecasts every response word and a monitor compares them.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   // One request word waiting to be driven.
   typedef struct packed {
      mode_type           mode;
      logic [SymbolW-1:0] symbol;
   } cmd_word_type;

   localparam int TimeoutNs = 3_000_000;
   localparam logic [CodeW-1:0] BootCodes [8] = '{8'd0, 8'd8, 8'd12, 8'd4,
                                                 8'd6, 8'd2, 8'd3, 8'd1};

   logic clock = 1'b0;
   logic reset;

   lps_req_if req_bus ();
   lps_rsp_if rsp_bus ();
   lps_csr_if csr_bus ();

   led_pattern_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Stimulus and forecast stores.
   cmd_word_type pending_words [$];
   rsp_type      predicted_rsp [$];
   int           errors = 0;

   // Idle rates in percent, and the long receiver hold-off.
   int   send_idle = 0;
   int   recv_idle = 0;
   logic hold_arm  = 1'b0;
   logic hold_done;
   int   hold_left;

   // Predictor copy of the block's state and registers.
   logic [CodeW-1:0]   model_store [PATTERN_DEPTH];
   logic [PosW-1:0]    model_pos;
   logic [LenW-1:0]    model_len;
   logic               model_loading;
   logic [LenW-1:0]    model_ld_idx;
   logic [LenW-1:0]    model_ld_len;
   logic [PeriodW-1:0] model_period;
   logic [PeriodW-1:0] model_count;
   logic               model_running;
   logic [LedW-1:0]    model_led;
   logic [PeriodW-1:0] model_floor;
   logic [PeriodW-1:0] model_ceiling;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bring the predictor to its power-up state.
   function automatic void reset_model();
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
         model_store[i] = (i < 8) ? BootCodes[i] : '0;
      end
      model_pos     = '0;
      model_len     = LenW'(8);
      model_loading = 1'b0;
      model_ld_idx  = '0;
      model_ld_len  = '0;
      model_period  = 16'd7441;
      model_count   = '0;
      model_running = 1'b1;
      model_led     = '0;
      model_floor   = 16'd1860;
      model_ceiling = 16'd29767;
   endfunction

   // Apply one request word to the predictor and return the response it forecasts.
   function automatic rsp_type advance_sequencer(mode_type mode, logic [SymbolW-1:0] symbol);
      rsp_type          word;
      int unsigned      nxt;
      int unsigned      p;
      logic [CodeW-1:0] code;
      logic [7:0]       value;
      case (mode)
         MODE_TICK: begin
            if (model_running) begin
               if (model_count >= model_period) begin
                  model_count = '0;
                  nxt = model_pos + 1;
                  if (nxt >= model_len || nxt >= PATTERN_DEPTH) nxt = 0;
                  model_pos = PosW'(nxt);
                  code = model_store[model_pos];
                  // Codes outside the chase table leave the LEDs as they are.
                  if (code inside {8'd0, 8'd8, 8'd12, 8'd4, 8'd6, 8'd2, 8'd3, 8'd1})
                     model_led = code[LedW-1:0];
               end else begin
                  model_count = model_count + 1'b1;
               end
            end
         end
         MODE_CHAR: begin
            value = symbol - CharZero;
            model_running = 1'b0;
            if (!model_loading) begin
               // A zero length is dropped; the block keeps waiting for a length.
               if (value != 0) begin
                  if (value > PATTERN_DEPTH) value = 8'(PATTERN_DEPTH);
                  model_ld_len  = LenW'(value);
                  model_ld_idx  = '0;
                  model_loading = 1'b1;
               end
            end else begin
               if (model_ld_idx < PATTERN_DEPTH)
                  model_store[model_ld_idx[PosW-1:0]] = value;
               model_ld_idx = model_ld_idx + 1'b1;
               if (model_ld_idx >= model_ld_len) begin
                  model_loading = 1'b0;
                  model_ld_idx  = '0;
                  model_pos     = '0;
                  model_len     = model_ld_len;
                  model_running = 1'b1;
               end
            end
         end
         MODE_FASTER: begin
            p = model_period / 2;
            if (p < model_floor) p = model_floor;
            model_period  = PeriodW'(p);
            model_count   = '0;
            model_running = 1'b1;
         end
         default: begin
            // Doubling is done wide so that it clamps rather than wraps.
            p = model_period * 2;
            if (p > model_ceiling) p = model_ceiling;
            model_period  = PeriodW'(p);
            model_count   = '0;
            model_running = 1'b1;
         end
      endcase
      word.leds     = model_led;
      word.position = PosOutW'(model_pos);
      word.loading  = model_loading;
      word.running  = model_running;
      return word;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic push_word(mode_type mode, logic [SymbolW-1:0] symbol);
      cmd_word_type w;
      w.mode   = mode;
      w.symbol = symbol;
      pending_words.push_back(w);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_csr(csr_idx_type idx, logic [PeriodW-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_PERIOD_MIN) model_floor = value;
      else model_ceiling = value;
      csr_bus.valid <= 1'b0;
   endtask

   // Wait until every queued word has gone in and every response has come out.
   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_bus.valid || predicted_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Random traffic: mostly complete pattern loads and runs of ticks, some noise.
   task automatic queue_random(int target);
      int         made;
      int         pick;
      int         len;
      int         n;
      logic [7:0] sym;
      made = 0;
      while (made < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++) push_word(MODE_TICK, SymbolW'($urandom));
            made += n;
         end else if (pick < 55) begin
            push_word($urandom_range(0, 1) ? MODE_FASTER : MODE_SLOWER, SymbolW'($urandom));
            made++;
         end else if (pick < 88) begin
            // Length character, now and then one that saturates at the store depth.
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 207) : $urandom_range(1, 8);
            push_word(MODE_CHAR, CharZero + SymbolW'(len));
            made++;
            n = (len > PATTERN_DEPTH) ? PATTERN_DEPTH : len;
            // Some loads are cut short, so the next character lands as an entry.
            if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  pick = $urandom_range(0, 2);
                  push_word(pick == 0 ? MODE_TICK : (pick == 1 ? MODE_FASTER : MODE_SLOWER),
                            SymbolW'($urandom));
                  made++;
               end
               if ($urandom_range(0, 4) != 0) sym = CharZero + BootCodes[$urandom_range(0, 7)];
               else sym = SymbolW'($urandom);
               push_word(MODE_CHAR, sym);
               made++;
            end
         end else begin
            push_word(mode_type'($urandom_range(0, 3)), SymbolW'($urandom));
            made++;
         end
      end
   endtask

   // Request driver: forecasts each accepted word, then offers the next one.
   always @(posedge clock) begin : drive_req
      cmd_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predicted_rsp.push_back(advance_sequencer(mode_type'(req_bus.mode), req_bus.symbol));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               w = pending_words.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.mode   <= w.mode;
               req_bus.symbol <= w.symbol;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed once from the stimulus sequence.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: compares each accepted word with the oldest forecast.
   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("response word with no forecast waiting");
               errors++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("leds", want.leds, rsp_bus.leds);
               check_field("position", want.position, rsp_bus.position);
               check_field("loading", want.loading, rsp_bus.loading);
               check_field("running", want.running, rsp_bus.running);
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // Stimulus sequence.
   initial begin
      reset_model();
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.mode   = MODE_TICK;
      req_bus.symbol = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = CSR_PERIOD_MIN;
      csr_bus.data   = '0;
      repeat (12) @(posedge clock);
      reset     <= 1'b0;
      send_idle <= 9;
      recv_idle <= 77;

      // Reset values: slow down into the ceiling, a zero length pauses, faster restarts.
      push_word(MODE_TICK, 8'hFF);
      push_word(MODE_SLOWER, 8'h00);
      push_word(MODE_SLOWER, 8'h00);
      push_word(MODE_SLOWER, 8'h00);
      push_word(MODE_CHAR, CharZero);
      push_word(MODE_TICK, 8'h00);
      push_word(MODE_FASTER, 8'hFF);
      drain();

      // Halving clamps up to a high floor; doubling from the top clamps at the ceiling.
      write_csr(CSR_PERIOD_MIN, 16'hFFFF);
      write_csr(CSR_PERIOD_MAX, 16'hFFFF);
      push_word(MODE_FASTER, 8'h00);
      drain();
      write_csr(CSR_PERIOD_MIN, 16'h0000);
      push_word(MODE_SLOWER, 8'h00);
      drain();

      // A zero ceiling gives a zero period, so every tick steps.
      write_csr(CSR_PERIOD_MAX, 16'h0000);
      push_word(MODE_SLOWER, 8'h00);
      push_word(MODE_TICK, 8'h00);
      push_word(MODE_TICK, 8'h55);
      // Three-entry load with one known and two unknown codes, one from a wrapped character.
      push_word(MODE_CHAR, CharZero + 8'd3);
      push_word(MODE_CHAR, CharZero + 8'd8);
      push_word(MODE_CHAR, CharZero + 8'd5);
      push_word(MODE_CHAR, 8'h00);
      push_word(MODE_TICK, 8'hAA);
      push_word(MODE_TICK, 8'h00);
      push_word(MODE_TICK, 8'h00);
      // Buttons during a load restart the counter but the load carries on.
      push_word(MODE_CHAR, CharZero + 8'd2);
      push_word(MODE_FASTER, 8'h00);
      push_word(MODE_CHAR, CharZero + 8'd1);
      push_word(MODE_CHAR, CharZero + 8'd6);
      push_word(MODE_TICK, 8'h00);
      push_word(MODE_TICK, 8'h00);
      drain();

      // Random phase with a busy receiver.
      write_csr(CSR_PERIOD_MIN, 16'd0);
      write_csr(CSR_PERIOD_MAX, 16'd6);
      queue_random(370);
      drain();

      // Random phase with a slow sender.
      send_idle <= 77;
      recv_idle <= 9;
      write_csr(CSR_PERIOD_MIN, 16'd2);
      write_csr(CSR_PERIOD_MAX, 16'd40);
      queue_random(370);
      drain();

      // Full rate, with one long receiver stall to back the block up.
      send_idle <= 0;
      recv_idle <= 0;
      write_csr(CSR_PERIOD_MIN, 16'hFFFF);
      write_csr(CSR_PERIOD_MAX, 16'h0000);
      hold_arm <= 1'b1;
      queue_random(370);
      drain();
      repeat (10) @(posedge clock);

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(TimeoutNs);
      $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_if.sv
rtl/led_pattern_sequencer.sv
dv/tb_top.sv
